// ===== rtl/core/pdlz_pkg.sv =====
// Shared types and constants of the PalmDOC LZ77 decompressor.
`timescale 1ns / 1ps

package pdlz_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 2048;
  localparam int unsigned DIST_W            = 11;
  localparam int unsigned COUNT_W           = 12;
  localparam int unsigned LEN_W             = 4;
  localparam int unsigned QUEUE_DEPTH       = 4;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 12'd2048;
  localparam logic [7:0]         RUN_MAX     = 8'h08;
  localparam logic [7:0]         PAIR_BASE   = 8'h80;
  localparam logic [7:0]         SPACE_BASE  = 8'hC0;
  localparam logic [7:0]         FLIP_MASK   = 8'h80;
  localparam logic [7:0]         SPACE_CHAR  = 8'h20;
  localparam logic [LEN_W-1:0]   LEN_BIAS    = 4'd3;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_SPACE,
    CMD_COPY,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [DIST_W-1:0] back_dist;
    logic [LEN_W-1:0]  len;
    logic              last;
  } cmd_t;

endpackage

// ===== rtl/core/pdlz_front.sv =====
// Front end: accept compressed words, track runs and pairs, issue commands.
`timescale 1ns / 1ps

module pdlz_front
  import pdlz_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_in_record
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [LEN_W-1:0]   lit_left_r, lit_left_nxt;
  logic               pair_r, pair_nxt;
  logic [5:0]         pair_hi_r, pair_hi_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               accept;
  logic               has_cmd;
  logic [COUNT_W-1:0] add;
  logic [COUNT_W-1:0] sum;
  logic [DIST_W-1:0]  back_dist;
  logic [LEN_W-1:0]   len;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && has_cmd;
  assign back_dist = {pair_hi_r, in_tdata[7:3]};
  assign len       = {1'b0, in_tdata[2:0]} + LEN_BIAS;
  assign sum       = count_r + add;

  always_comb begin
    has_cmd         = 1'b0;
    add             = '0;
    lit_left_nxt    = lit_left_r;
    pair_nxt        = pair_r;
    pair_hi_nxt     = pair_hi_r;
    q_cmd.kind      = CMD_LIT;
    q_cmd.data      = in_tdata;
    q_cmd.back_dist = back_dist;
    q_cmd.len       = len;
    q_cmd.last      = in_tlast;
    priority if (lit_left_r != '0) begin
      has_cmd      = 1'b1;
      add          = 12'd1;
      lit_left_nxt = lit_left_r - 1'b1;
    end else if (pair_r) begin
      has_cmd     = 1'b1;
      pair_nxt    = 1'b0;
      pair_hi_nxt = '0;
      if (back_dist == '0 || {1'b0, back_dist} > count_r) begin
        q_cmd.kind = CMD_BAD;
      end else begin
        q_cmd.kind = CMD_COPY;
        add        = {{(COUNT_W-LEN_W){1'b0}}, len};
      end
    end else if (in_tdata != 8'h00 && in_tdata <= RUN_MAX) begin
      lit_left_nxt = in_tdata[LEN_W-1:0];
    end else if (in_tdata < PAIR_BASE) begin
      has_cmd = 1'b1;
      add     = 12'd1;
    end else if (in_tdata >= SPACE_BASE) begin
      has_cmd    = 1'b1;
      add        = 12'd2;
      q_cmd.kind = CMD_SPACE;
      q_cmd.data = in_tdata ^ FLIP_MASK;
    end else begin
      pair_nxt    = 1'b1;
      pair_hi_nxt = in_tdata[5:0];
    end
    count_nxt = (sum > COUNT_LIMIT) ? COUNT_LIMIT : sum;
    if (in_tlast) begin
      lit_left_nxt = '0;
      pair_nxt     = 1'b0;
      pair_hi_nxt  = '0;
      count_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_left_r <= '0;
      pair_r     <= 1'b0;
      pair_hi_r  <= '0;
      count_r    <= '0;
    end else if (accept) begin
      lit_left_r <= lit_left_nxt;
      pair_r     <= pair_nxt;
      pair_hi_r  <= pair_hi_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/pdlz_queue.sv =====
// Short command queue between front and back end.
`timescale 1ns / 1ps

module pdlz_queue
  import pdlz_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   fill_r;

  assign full  = (fill_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid = (fill_r != '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/pdlz_back.sv =====
// Back end: run commands against the history memory and drive the output words.
`timescale 1ns / 1ps

module pdlz_back
  import pdlz_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_of_run
  output logic [1:0] out_tuser   // [0] record_done, [1] bad_reference
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPACE,
    S_CREAD,
    S_CDATA
  } state_t;

  logic [7:0] hist_mem [HISTORY_DEPTH];

  state_t            state_r, state_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic              last_r, last_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [7:0]        rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_bad_r, out_bad_nxt;

  logic              can_emit;
  logic              we;
  logic [7:0]        wdata;
  logic              rd_en;
  logic [DIST_W-1:0] dist_sel;
  logic [AW:0]       wp_ext;
  logic [AW:0]       dist_ext;
  logic [AW:0]       src_ext;
  logic [AW-1:0]     rd_addr;

  assign can_emit = !out_valid_r || out_tready;
  assign dist_sel = (state_r == S_IDLE) ? cmd.back_dist : dist_r;
  assign wp_ext   = {1'b0, wp_r};
  assign dist_ext = (AW+1)'(dist_sel);
  assign src_ext  = (wp_ext >= dist_ext) ? (wp_ext - dist_ext)
                  : (wp_ext + (AW+1)'(HISTORY_DEPTH) - dist_ext);
  assign rd_addr  = src_ext[AW-1:0];

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_done_r;
  assign out_tuser[1] = out_bad_r;

  always_comb begin
    state_nxt     = state_r;
    dist_nxt      = dist_r;
    left_nxt      = left_r;
    last_nxt      = last_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    out_bad_nxt   = out_bad_r;
    cmd_pop       = 1'b0;
    we            = 1'b0;
    wdata         = out_byte_r;
    rd_en         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && can_emit) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_LIT: begin
              we            = 1'b1;
              wdata         = cmd.data;
              out_valid_nxt = 1'b1;
              out_byte_nxt  = cmd.data;
              out_last_nxt  = 1'b1;
              out_done_nxt  = cmd.last;
              out_bad_nxt   = 1'b0;
            end
            CMD_SPACE: begin
              we            = 1'b1;
              wdata         = SPACE_CHAR;
              out_valid_nxt = 1'b1;
              out_byte_nxt  = SPACE_CHAR;
              out_last_nxt  = 1'b0;
              out_done_nxt  = 1'b0;
              out_bad_nxt   = 1'b0;
              hold_nxt      = cmd.data;
              last_nxt      = cmd.last;
              state_nxt     = S_SPACE;
            end
            CMD_BAD: begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = '0;
              out_last_nxt  = 1'b1;
              out_done_nxt  = cmd.last;
              out_bad_nxt   = 1'b1;
            end
            CMD_COPY: begin
              rd_en     = 1'b1;
              dist_nxt  = cmd.back_dist;
              left_nxt  = cmd.len;
              last_nxt  = cmd.last;
              state_nxt = S_CDATA;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SPACE: begin
        if (can_emit) begin
          we            = 1'b1;
          wdata         = hold_r;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = hold_r;
          out_last_nxt  = 1'b1;
          out_done_nxt  = last_r;
          out_bad_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_CREAD: begin
        rd_en     = 1'b1;
        state_nxt = S_CDATA;
      end
      S_CDATA: begin
        if (can_emit) begin
          we            = 1'b1;
          wdata         = rd_data_r;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data_r;
          out_last_nxt  = (left_r == 4'd1);
          out_done_nxt  = (left_r == 4'd1) && last_r;
          out_bad_nxt   = 1'b0;
          left_nxt      = left_r - 1'b1;
          state_nxt     = (left_r == 4'd1) ? S_IDLE : S_CREAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    wp_nxt = wp_r;
    if (we) begin
      wp_nxt = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      hist_mem[wp_r] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
      dist_r      <= '0;
      left_r      <= '0;
      last_r      <= 1'b0;
      hold_r      <= '0;
      out_byte_r  <= '0;
      out_last_r  <= 1'b0;
      out_done_r  <= 1'b0;
      out_bad_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
      dist_r      <= dist_nxt;
      left_r      <= left_nxt;
      last_r      <= last_nxt;
      hold_r      <= hold_nxt;
      out_byte_r  <= out_byte_nxt;
      out_last_r  <= out_last_nxt;
      out_done_r  <= out_done_nxt;
      out_bad_r   <= out_bad_nxt;
    end
  end

endmodule

// ===== rtl/core/palmdoc_lz77_decompressor.sv =====
// PalmDOC LZ77 record decompressor, top level.
`timescale 1ns / 1ps

// One compressed byte enters per word on the in_ stream, one decoded byte leaves per
// word on the out_ stream. The front end takes a compressed word every cycle while its
// four-entry command queue has room; the back end emits a literal or a bad reference
// as one word, a space pair as a space and then the flipped byte, and a back-reference
// of 3 to 10 bytes as a history read, then a write-back, for each copied byte.
// The single-port-read history memory paces the copy. out_tlast marks the last decoded
// word of each compressed byte; out_tuser[0] marks the last word of a record and
// out_tuser[1] a bad back-reference (data 0). A run-opening byte or the first byte of a
// pair yields no word. The history needs no clearing after reset.

module palmdoc_lz77_decompressor
  import pdlz_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_in_record
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_of_run
  output logic [1:0] out_tuser   // [0] record_done, [1] bad_reference
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  pdlz_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  pdlz_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  pdlz_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd        (q_head),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
